// File: sv/sonar_pixel_to_polar_min_range_bins_assert.svh
// Assertion helpers for the sonar binning controller.
`ifndef SONAR_PIXEL_TO_POLAR_MIN_RANGE_BINS_ASSERT_SVH
`define SONAR_PIXEL_TO_POLAR_MIN_RANGE_BINS_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define SPMB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("spmb assertion failed");

// Check that a condition is followed by another on the next cycle.
`define SPMB_ASSERT_NEXT(lbl, clk, rst, a, b) \
   `SPMB_ASSERT(lbl, clk, rst, (a) |=> (b))

`endif

// File: sv/spmb_pkg.sv
`default_nettype none
package spmb_pkg;

   localparam int NUM_BINS   = 180;
   localparam int BIN_W      = 8;
   localparam int XQ_W       = 32;
   localparam int CX_W       = 34;
   localparam int Z_W        = 18;
   localparam int DVD_W      = 17;
   localparam int ROT_STEPS  = 16;
   localparam int DIV_STEPS  = 17;
   localparam int CNT_W      = 5;
   localparam int ADDR_W     = 5;
   localparam logic [15:0] GAIN_INV = 16'd39797;

   localparam logic [2:0] REG_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_CENTRE    = 3'd1;
   localparam logic [2:0] REG_ORIGIN    = 3'd2;
   localparam logic [2:0] REG_MPP       = 3'd3;
   localparam logic [2:0] REG_LIMIT     = 3'd4;
   localparam logic [2:0] REG_START     = 3'd5;
   localparam logic [2:0] REG_WIDTH     = 3'd6;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_MEM, S_RD_OUT, S_MUL, S_PRE, S_ROT, S_RNG, S_DIV, S_BIN_RD, S_UPD
   } state_type;

   typedef struct packed {
      logic [7:0]         bright_threshold;
      logic [9:0]         centre_column;
      logic [9:0]         origin_row;
      logic [19:0]        metres_per_pixel;
      logic [15:0]        range_limit;
      logic signed [15:0] angle_start;
      logic [15:0]        bin_width;
   } cfg_type;

   typedef struct packed {
      logic             capture;
      logic             rd_req;
      logic             rd_out;
      logic             mul;
      logic             pre;
      logic             rot;
      logic             rng;
      logic             div_step;
      logic             bin_rd;
      logic             upd;
      logic [CNT_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic echo;
   } status_type;

   function automatic logic signed [15:0] q20_to_q12(input logic signed [XQ_W-1:0] v);
      logic [XQ_W-1:0] mag;
      logic [XQ_W-1:0] r;
      logic signed [15:0] res;
      mag = v[XQ_W-1] ? XQ_W'(-v) : XQ_W'(v);
      r = (mag + XQ_W'(128)) >> 8;
      if (v[XQ_W-1]) begin
         if (r > XQ_W'(32768)) res = 16'sh8000;
         else res = 16'(-r);
      end else begin
         if (r > XQ_W'(32767)) res = 16'sh7FFF;
         else res = 16'(r);
      end
      return res;
   endfunction

   function automatic logic signed [Z_W-1:0] atan_entry(input logic [3:0] i);
      logic signed [Z_W-1:0] a;
      unique case (i)
         4'd0: a = 18'sd8192;
         4'd1: a = 18'sd4836;
         4'd2: a = 18'sd2555;
         4'd3: a = 18'sd1297;
         4'd4: a = 18'sd651;
         4'd5: a = 18'sd326;
         4'd6: a = 18'sd163;
         4'd7: a = 18'sd81;
         4'd8: a = 18'sd41;
         4'd9: a = 18'sd20;
         4'd10: a = 18'sd10;
         4'd11: a = 18'sd5;
         4'd12: a = 18'sd3;
         4'd13: a = 18'sd1;
         4'd14: a = 18'sd1;
         default: a = 18'sd0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

// File: sv/spmb_csr.sv
`default_nettype none
module spmb_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               psel,
   input  wire                               penable,
   input  wire                               pwrite,
   input  wire  [spmb_pkg::ADDR_W-1:0]       paddr,
   input  wire  [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output spmb_pkg::cfg_type                 cfg
);

   spmb_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0] idx;

   assign idx = paddr[4:2];
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (idx)
            spmb_pkg::REG_THRESHOLD: cfg_in.bright_threshold = pwdata[7:0];
            spmb_pkg::REG_CENTRE:    cfg_in.centre_column = pwdata[9:0];
            spmb_pkg::REG_ORIGIN:    cfg_in.origin_row = pwdata[9:0];
            spmb_pkg::REG_MPP:       cfg_in.metres_per_pixel = pwdata[19:0];
            spmb_pkg::REG_LIMIT:     cfg_in.range_limit = pwdata[15:0];
            spmb_pkg::REG_START:     cfg_in.angle_start = signed'(pwdata[15:0]);
            spmb_pkg::REG_WIDTH:     cfg_in.bin_width = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         spmb_pkg::REG_THRESHOLD: prdata = {24'd0, cfg_ff.bright_threshold};
         spmb_pkg::REG_CENTRE:    prdata = {22'd0, cfg_ff.centre_column};
         spmb_pkg::REG_ORIGIN:    prdata = {22'd0, cfg_ff.origin_row};
         spmb_pkg::REG_MPP:       prdata = {12'd0, cfg_ff.metres_per_pixel};
         spmb_pkg::REG_LIMIT:     prdata = {16'd0, cfg_ff.range_limit};
         spmb_pkg::REG_START:     prdata = {16'd0, cfg_ff.angle_start};
         spmb_pkg::REG_WIDTH:     prdata = {16'd0, cfg_ff.bin_width};
         default:                 prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bright_threshold <= 8'd127;
         cfg_ff.centre_column    <= 10'd127;
         cfg_ff.origin_row       <= 10'd425;
         cfg_ff.metres_per_pixel <= 20'd2960;
         cfg_ff.range_limit      <= 16'd4915;
         cfg_ff.angle_start      <= -16'sd10923;
         cfg_ff.bin_width        <= 16'd364;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/spmb_datapath.sv
`default_nettype none
module spmb_datapath (
   input  wire                        clock,
   input  wire                        reset,
   input  spmb_pkg::cfg_type          cfg,
   input  spmb_pkg::cmd_type          cmd,
   output spmb_pkg::status_type       status,
   input  wire                        req_command,
   input  wire  [9:0]                 req_column,
   input  wire  [9:0]                 req_row,
   input  wire  [7:0]                 req_brightness,
   input  wire  [7:0]                 req_read_bin,
   output logic                       rsp_valid,
   output logic                       rsp_kind,
   output logic signed [15:0]         rsp_point_x,
   output logic signed [15:0]         rsp_point_y,
   output logic [7:0]                 rsp_bin_number,
   output logic [15:0]                rsp_bin_range
);

   localparam int XQ_W  = spmb_pkg::XQ_W;
   localparam int CX_W  = spmb_pkg::CX_W;
   localparam int Z_W   = spmb_pkg::Z_W;
   localparam int DVD_W = spmb_pkg::DVD_W;
   localparam int BIN_W = spmb_pkg::BIN_W;
   localparam int NB    = spmb_pkg::NUM_BINS;

   logic [9:0]              col_ff, row_ff;
   logic [7:0]              rbin_ff;
   logic signed [XQ_W-1:0]  xq_ff, yq_ff;
   logic signed [CX_W-1:0]  cx_ff, cy_ff;
   logic signed [Z_W-1:0]   z_ff;
   logic                    zero_ff;
   logic [15:0]             range_ff;
   logic [DVD_W-1:0]        dvd_ff;
   logic [15:0]             rem_ff;
   logic                    neg_ff;
   logic                    bin_ok_ff;
   logic [15:0]             mem [0:NB-1];
   logic [15:0]             mem_q_ff;
   logic [NB-1:0]           written_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_kind_ff;
   logic signed [15:0]      rsp_x_ff, rsp_y_ff;
   logic [7:0]              rsp_bin_ff;
   logic [15:0]             rsp_range_ff;

   logic signed [10:0]      dx, dy;
   logic signed [20:0]      mpp_s;
   logic signed [CX_W-1:0]  xs, ys;
   logic signed [Z_W-1:0]   atan_v;
   logic [32:0]             xpos;
   logic [49:0]             rprod;
   logic [25:0]             rshift;
   logic signed [Z_W-1:0]   ang;
   logic signed [Z_W-1:0]   diff;
   logic [16:0]             trial;
   logic                    rbin_in;
   logic [BIN_W-1:0]        bin_idx;
   logic [15:0]             cur;

   assign status.is_read = req_command;
   assign status.echo    = req_brightness > cfg.bright_threshold;

   assign dx    = signed'({1'b0, col_ff}) - signed'({1'b0, cfg.centre_column});
   assign dy    = signed'({1'b0, cfg.origin_row}) - signed'({1'b0, row_ff});
   assign mpp_s = signed'({1'b0, cfg.metres_per_pixel});

   assign xs     = cx_ff >>> cmd.step[3:0];
   assign ys     = cy_ff >>> cmd.step[3:0];
   assign atan_v = spmb_pkg::atan_entry(cmd.step[3:0]);

   assign xpos   = cx_ff[CX_W-1] ? 33'd0 : cx_ff[32:0];
   assign rprod  = 50'(xpos * spmb_pkg::GAIN_INV) + 50'(1 << 23);
   assign rshift = rprod[49:24];

   always_comb begin
      if (zero_ff) ang = '0;
      else if (z_ff > 18'sd32768) ang = 18'sd32768;
      else if (z_ff < -18'sd32768) ang = -18'sd32768;
      else ang = z_ff;
   end
   assign diff = ang - Z_W'(cfg.angle_start);

   assign trial   = {rem_ff, dvd_ff[DVD_W-1]};
   assign rbin_in = rbin_ff < BIN_W'(NB);
   assign bin_idx = dvd_ff[BIN_W-1:0];
   assign cur     = written_ff[bin_idx] ? mem_q_ff : cfg.range_limit;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_ff  <= req_column;
         row_ff  <= req_row;
         rbin_ff <= req_read_bin;
      end
      if (cmd.mul) begin
         xq_ff <= XQ_W'(dx * mpp_s);
         yq_ff <= XQ_W'(dy * mpp_s);
      end
      if (cmd.pre) begin
         zero_ff <= (xq_ff == '0) && (yq_ff == '0);
         if (xq_ff < 0) begin
            if (yq_ff >= 0) begin
               cx_ff <= CX_W'(yq_ff);
               cy_ff <= -CX_W'(xq_ff);
               z_ff  <= 18'sd16384;
            end else begin
               cx_ff <= -CX_W'(yq_ff);
               cy_ff <= CX_W'(xq_ff);
               z_ff  <= -18'sd16384;
            end
         end else begin
            cx_ff <= CX_W'(xq_ff);
            cy_ff <= CX_W'(yq_ff);
            z_ff  <= '0;
         end
      end
      if (cmd.rot) begin
         if (cy_ff >= 0) begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            z_ff  <= z_ff + atan_v;
         end else begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            z_ff  <= z_ff - atan_v;
         end
      end
      if (cmd.rng) begin
         if (zero_ff) range_ff <= '0;
         else if (rshift > 26'd65535) range_ff <= 16'hFFFF;
         else range_ff <= rshift[15:0];
         neg_ff <= diff[Z_W-1];
         dvd_ff <= diff[DVD_W-1:0];
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         if (trial >= {1'b0, cfg.bin_width}) begin
            rem_ff <= 16'(trial - {1'b0, cfg.bin_width});
            dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[15:0];
            dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         end
      end
      if (cmd.bin_rd) begin
         bin_ok_ff <= (cfg.bin_width != '0) && !neg_ff && (dvd_ff < DVD_W'(NB));
         mem_q_ff  <= mem[bin_idx];
      end
      if (cmd.rd_req) begin
         mem_q_ff <= mem[rbin_ff];
      end
      if (cmd.upd && bin_ok_ff && (range_ff < cur)) begin
         mem[bin_idx] <= range_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (cmd.upd && bin_ok_ff && (range_ff < cur)) begin
         written_ff[bin_idx] <= 1'b1;
      end else if (cmd.rd_out && rbin_in) begin
         written_ff[rbin_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.upd || cmd.rd_out;
      end
      if (cmd.upd) begin
         rsp_kind_ff  <= 1'b0;
         rsp_x_ff     <= spmb_pkg::q20_to_q12(xq_ff);
         rsp_y_ff     <= spmb_pkg::q20_to_q12(yq_ff);
         rsp_bin_ff   <= '0;
         rsp_range_ff <= '0;
      end else if (cmd.rd_out) begin
         rsp_kind_ff  <= 1'b1;
         rsp_x_ff     <= '0;
         rsp_y_ff     <= '0;
         rsp_bin_ff   <= rbin_ff;
         rsp_range_ff <= (rbin_in && written_ff[rbin_ff]) ? mem_q_ff : cfg.range_limit;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_point_x    = rsp_x_ff;
   assign rsp_point_y    = rsp_y_ff;
   assign rsp_bin_number = rsp_bin_ff;
   assign rsp_bin_range  = rsp_range_ff;

endmodule
`default_nettype wire

// File: sv/spmb_ctrl.sv
`default_nettype none
`include "sonar_pixel_to_polar_min_range_bins_assert.svh"
module spmb_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  spmb_pkg::status_type  status,
   output spmb_pkg::cmd_type     cmd
);

   localparam int CNT_W = spmb_pkg::CNT_W;

   spmb_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                accept;

   assign busy   = state_ff != spmb_pkg::S_IDLE;
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      cmd.step = count_ff;
      unique case (state_ff)
         spmb_pkg::S_IDLE: begin
            count_in = '0;
            if (accept) begin
               cmd.capture = 1'b1;
               if (status.is_read) state_in = spmb_pkg::S_RD_MEM;
               else if (status.echo) state_in = spmb_pkg::S_MUL;
            end
         end
         spmb_pkg::S_RD_MEM: begin
            cmd.rd_req = 1'b1;
            state_in   = spmb_pkg::S_RD_OUT;
         end
         spmb_pkg::S_RD_OUT: begin
            cmd.rd_out = 1'b1;
            state_in   = spmb_pkg::S_IDLE;
         end
         spmb_pkg::S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = spmb_pkg::S_PRE;
         end
         spmb_pkg::S_PRE: begin
            cmd.pre  = 1'b1;
            state_in = spmb_pkg::S_ROT;
         end
         spmb_pkg::S_ROT: begin
            cmd.rot  = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_W'(spmb_pkg::ROT_STEPS - 1)) begin
               count_in = '0;
               state_in = spmb_pkg::S_RNG;
            end
         end
         spmb_pkg::S_RNG: begin
            cmd.rng  = 1'b1;
            state_in = spmb_pkg::S_DIV;
         end
         spmb_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == CNT_W'(spmb_pkg::DIV_STEPS - 1)) begin
               count_in = '0;
               state_in = spmb_pkg::S_BIN_RD;
            end
         end
         spmb_pkg::S_BIN_RD: begin
            cmd.bin_rd = 1'b1;
            state_in   = spmb_pkg::S_UPD;
         end
         spmb_pkg::S_UPD: begin
            cmd.upd  = 1'b1;
            state_in = spmb_pkg::S_IDLE;
         end
         default: state_in = spmb_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spmb_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   `SPMB_ASSERT_NEXT(a_read_path, clock, reset, accept && status.is_read, state_ff == spmb_pkg::S_RD_MEM)
   `SPMB_ASSERT(a_rot_count, clock, reset, (state_ff == spmb_pkg::S_ROT) |-> (count_ff < CNT_W'(spmb_pkg::ROT_STEPS)))
   `SPMB_ASSERT(a_div_count, clock, reset, (state_ff == spmb_pkg::S_DIV) |-> (count_ff < CNT_W'(spmb_pkg::DIV_STEPS)))
   `SPMB_ASSERT_NEXT(a_emit_idle, clock, reset, cmd.upd || cmd.rd_out, state_ff == spmb_pkg::S_IDLE && !cmd.upd && !cmd.rd_out)

endmodule
`default_nettype wire

// File: sv/sonar_pixel_to_polar_min_range_bins.sv
// Channel   Ports                                    Handshake
// input     req_command req_column req_row ...      start high while busy low
// result    rsp_kind rsp_point_x ... rsp_bin_range  rsp_valid for one cycle
// config    psel penable pwrite paddr pwdata prdata APB, pready tied high
//
// A bright pixel passes through product, pre-rotation, 16 CORDIC steps,
// range, 17 steps of the bit-serial bin divider, bin read and update.
// A bin read passes through memory read and output; a dim pixel is dropped.
// Bin state clears at reset through per-bin valid bits, no sweep.
// The result strobe cannot be held off; busy holds off new transactions.
`default_nettype none
module sonar_pixel_to_polar_min_range_bins (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire                               req_command,
   input  wire  [9:0]                        req_column,
   input  wire  [9:0]                        req_row,
   input  wire  [7:0]                        req_brightness,
   input  wire  [7:0]                        req_read_bin,
   output logic                              rsp_valid,
   output logic                              rsp_kind,
   output logic signed [15:0]                rsp_point_x,
   output logic signed [15:0]                rsp_point_y,
   output logic [7:0]                        rsp_bin_number,
   output logic [15:0]                       rsp_bin_range,
   input  wire                               psel,
   input  wire                               penable,
   input  wire                               pwrite,
   input  wire  [spmb_pkg::ADDR_W-1:0]       paddr,
   input  wire  [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   spmb_pkg::cfg_type    cfg;
   spmb_pkg::cmd_type    cmd;
   spmb_pkg::status_type status;

   assign pready = 1'b1;

   spmb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   spmb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   spmb_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .req_command    (req_command),
      .req_column     (req_column),
      .req_row        (req_row),
      .req_brightness (req_brightness),
      .req_read_bin   (req_read_bin),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_bin_number (rsp_bin_number),
      .rsp_bin_range  (rsp_bin_range)
   );

endmodule
`default_nettype wire
